// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SRB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sprite blitter check failed");

`define SRB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    `SRB_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`define SRB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    `SRB_ASSERT(label, clk, rst_n, (ante) |=> (cons))

`endif

// ===== src/srb_pkg.sv =====
// Types and constants of the sprite RLE blitter
package srb_pkg;

    localparam int OUT_ADDR_W = 20;
    localparam int RUN_W      = 12;
    localparam int WORD_W     = 16;
    localparam int PITCH_W    = 12;
    localparam int CFG_IDX_W  = 2;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 12'd640;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH    = 2'd3;

    localparam logic [3:0] PH_HDR_LO = 4'd0;
    localparam logic [3:0] PH_HDR_HI = 4'd1;
    localparam logic [3:0] PH_OY_LO  = 4'd2;
    localparam logic [3:0] PH_OY_HI  = 4'd3;
    localparam logic [3:0] PH_OX_LO  = 4'd4;
    localparam logic [3:0] PH_OX_HI  = 4'd5;
    localparam logic [3:0] PH_W_LO   = 4'd6;
    localparam logic [3:0] PH_W_HI   = 4'd7;
    localparam logic [3:0] PH_H_LO   = 4'd8;
    localparam logic [3:0] PH_H_HI   = 4'd9;
    localparam logic [3:0] PH_RAW    = 4'd10;
    localparam logic [3:0] PH_CTL_LO = 4'd11;
    localparam logic [3:0] PH_CTL_HI = 4'd12;
    localparam logic [3:0] PH_LIT    = 4'd13;
    localparam logic [3:0] PH_DONE   = 4'd14;

    typedef struct packed {
        logic [WORD_W-1:0]  origin_x;
        logic [WORD_W-1:0]  origin_y;
        logic               keep;
        logic [PITCH_W-1:0] pitch;
    } t_cfg;

    typedef struct packed {
        logic                  valid;
        logic [OUT_ADDR_W-1:0] addr;
        logic [7:0]            value;
        logic [RUN_W-1:0]      count;
        logic                  last;
    } t_result;

endpackage

// ===== src/srb_parser.sv =====
// Record parser: parse state and the write command caused by one byte
module srb_parser #(
    parameter int ADDR_BITS = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_first,
    input  srb_pkg::t_cfg    i_cfg,
    output srb_pkg::t_result o_res
);
    import srb_pkg::*;

    logic [3:0]           r_phase, n_phase;
    logic [7:0]           r_lo, n_lo;
    logic                 r_rle, n_rle;
    logic [WORD_W-1:0]    r_offy, n_offy;
    logic [WORD_W-1:0]    r_width, n_width;
    logic [WORD_W-1:0]    r_rows, n_rows;
    logic [WORD_W-1:0]    r_cols, n_cols;
    logic [RUN_W-1:0]     r_run, n_run;
    logic                 r_rep, n_rep;
    logic [ADDR_BITS-1:0] r_rsa, n_rsa;
    logic [ADDR_BITS-1:0] r_cur, n_cur;

    logic [3:0]           phase;
    logic [WORD_W-1:0]    word;
    logic [RUN_W-1:0]     run_len;
    logic [WORD_W:0]      y_sum;
    logic [WORD_W:0]      x_sum;
    logic [28:0]          prod;
    logic [29:0]          org_sum;
    logic [ADDR_BITS-1:0] origin;
    logic [ADDR_BITS-1:0] rsa_step;
    logic [ADDR_BITS-1:0] cur_inc;
    logic [ADDR_BITS-1:0] cur_skip;
    logic [WORD_W-1:0]    rows_dec;
    logic [WORD_W-1:0]    cols_dec;
    logic [RUN_W-1:0]     run_dec;
    logic                 rows_end;
    logic                 pix_write;
    logic                 fin;

    assign phase    = i_first ? PH_HDR_LO : r_phase;
    assign word     = {i_byte, r_lo};
    assign run_len  = word[RUN_W-1:0];
    assign y_sum    = {1'b0, i_cfg.origin_y}
                    + {1'b0, (phase == PH_OX_HI) ? r_offy : {WORD_W{1'b0}}};
    assign x_sum    = {1'b0, i_cfg.origin_x}
                    + {1'b0, (phase == PH_OX_HI) ? word : {WORD_W{1'b0}}};
    assign prod     = i_cfg.pitch * y_sum;
    assign org_sum  = {1'b0, prod} + 30'(x_sum);
    assign origin   = ADDR_BITS'(org_sum);
    assign rsa_step = r_rsa + ADDR_BITS'(i_cfg.pitch);
    assign cur_inc  = r_cur + ADDR_BITS'(1);
    assign cur_skip = r_cur + ADDR_BITS'(run_len);
    assign rows_dec = r_rows - 16'd1;
    assign cols_dec = r_cols - 16'd1;
    assign run_dec  = r_run - 12'd1;
    assign rows_end = (rows_dec == '0);
    assign pix_write = !(i_cfg.keep && i_byte == 8'd0);

    always_comb begin
        n_phase = r_phase;
        n_lo    = r_lo;
        n_rle   = r_rle;
        n_offy  = r_offy;
        n_width = r_width;
        n_rows  = r_rows;
        n_cols  = r_cols;
        n_run   = r_run;
        n_rep   = r_rep;
        n_rsa   = r_rsa;
        n_cur   = r_cur;
        o_res   = '0;
        fin     = 1'b0;
        if (i_step) begin
            n_phase = phase;
            unique case (phase)
                PH_HDR_LO, PH_OY_LO, PH_OX_LO, PH_W_LO, PH_H_LO, PH_CTL_LO: begin
                    n_lo    = i_byte;
                    n_phase = phase + 4'd1;
                end
                PH_HDR_HI: begin
                    n_rle = word[0];
                    if (word[1]) begin
                        n_phase = PH_OY_LO;
                    end else begin
                        n_offy  = '0;
                        n_rsa   = origin;
                        n_phase = PH_W_LO;
                    end
                end
                PH_OY_HI: begin
                    n_offy  = word;
                    n_phase = PH_OX_LO;
                end
                PH_OX_HI: begin
                    n_rsa   = origin;
                    n_phase = PH_W_LO;
                end
                PH_W_HI: begin
                    n_width = word;
                    if (word == '0) begin
                        n_phase    = PH_DONE;
                        o_res.valid = 1'b1;
                        o_res.last  = 1'b1;
                    end else begin
                        n_phase = PH_H_LO;
                    end
                end
                PH_H_HI: begin
                    if (word == '0) begin
                        n_phase    = PH_DONE;
                        o_res.valid = 1'b1;
                        o_res.last  = 1'b1;
                    end else begin
                        n_rows  = word;
                        n_cols  = r_width;
                        n_cur   = r_rsa;
                        n_run   = '0;
                        n_rep   = 1'b0;
                        n_phase = r_rle ? PH_CTL_LO : PH_RAW;
                    end
                end
                PH_RAW: begin
                    n_cur  = cur_inc;
                    n_cols = cols_dec;
                    if (cols_dec == '0) begin
                        n_cols = r_width;
                        n_rsa  = rsa_step;
                        n_cur  = rsa_step;
                        n_rows = rows_dec;
                        fin    = rows_end;
                        if (rows_end) begin
                            n_phase = PH_DONE;
                        end
                    end
                    if (pix_write) begin
                        o_res.valid = 1'b1;
                        o_res.addr  = OUT_ADDR_W'(r_cur);
                        o_res.value = i_byte;
                        o_res.count = 12'd1;
                        o_res.last  = fin;
                    end else if (fin) begin
                        o_res.valid = 1'b1;
                        o_res.last  = 1'b1;
                    end
                end
                PH_CTL_HI: begin
                    if (!word[15] && run_len != '0) begin
                        n_run   = run_len;
                        n_rep   = word[14];
                        n_phase = PH_LIT;
                    end else begin
                        n_phase = PH_CTL_LO;
                        if (word[15]) begin
                            n_cur = cur_skip;
                            if (!i_cfg.keep && run_len != '0) begin
                                o_res.valid = 1'b1;
                                o_res.addr  = OUT_ADDR_W'(r_cur);
                                o_res.count = run_len;
                            end
                        end
                        if (word[14]) begin
                            n_rsa  = rsa_step;
                            n_cur  = rsa_step;
                            n_rows = rows_dec;
                            if (rows_end) begin
                                n_phase     = PH_DONE;
                                o_res.valid = 1'b1;
                                o_res.last  = 1'b1;
                            end
                        end
                    end
                end
                PH_LIT: begin
                    n_cur = cur_inc;
                    n_run = run_dec;
                    if (run_dec == '0) begin
                        n_phase = PH_CTL_LO;
                        if (r_rep) begin
                            n_rep  = 1'b0;
                            n_rsa  = rsa_step;
                            n_cur  = rsa_step;
                            n_rows = rows_dec;
                            fin    = rows_end;
                            if (rows_end) begin
                                n_phase = PH_DONE;
                            end
                        end
                    end
                    o_res.valid = 1'b1;
                    o_res.addr  = OUT_ADDR_W'(r_cur);
                    o_res.value = i_byte;
                    o_res.count = 12'd1;
                    o_res.last  = fin;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HDR_LO;
            r_lo    <= '0;
            r_rle   <= 1'b0;
            r_offy  <= '0;
            r_width <= '0;
            r_rows  <= '0;
            r_cols  <= '0;
            r_run   <= '0;
            r_rep   <= 1'b0;
            r_rsa   <= '0;
            r_cur   <= '0;
        end else begin
            r_phase <= n_phase;
            r_lo    <= n_lo;
            r_rle   <= n_rle;
            r_offy  <= n_offy;
            r_width <= n_width;
            r_rows  <= n_rows;
            r_cols  <= n_cols;
            r_run   <= n_run;
            r_rep   <= n_rep;
            r_rsa   <= n_rsa;
            r_cur   <= n_cur;
        end
    end

endmodule

// ===== src/sprite_rle_blitter_unit.sv =====
// Sprite RLE blitter top level: input register, parser, result register, config
// The block takes one sprite record byte per cycle while the output side accepts
// its commands, and keeps that rate under any mix of raw, fill, skip and literal
// data: each byte passes through an input register, the parse logic (the
// start-address multiply-add is the longest path) and a result register, which
// holds its write command for the output. While a command waits on the output
// side, the input register can still take one more byte. Bytes that write
// nothing produce no output unless they finish a record. The configuration port
// is always ready; write it only while no record bytes are in flight.
module sprite_rle_blitter_unit #(
    parameter int ADDR_BITS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
    input  logic                              s_axis_tuser,  // [0] first
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [19:0] write_address, [27:20] pixel_value, [39:28] repeat_count
    output logic [39:0]                       m_axis_tdata,
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [srb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);
    import srb_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    logic    r_first;
    logic [7:0] r_byte;
    logic    r_out_valid;
    t_result r_out;
    t_result res;
    logic    adv;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign o_cfg_ready   = 1'b1;

    srb_parser #(
        .ADDR_BITS(ADDR_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_byte  (r_byte),
        .i_first (r_first),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= '0;
            r_cfg.origin_y <= '0;
            r_cfg.keep     <= 1'b0;
            r_cfg.pitch    <= PITCH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X: r_cfg.origin_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_cfg.origin_y <= i_cfg_data;
                CFG_KEEP:     r_cfg.keep     <= i_cfg_data[0];
                CFG_PITCH:    r_cfg.pitch    <= i_cfg_data[PITCH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_byte  <= s_axis_tdata;
            r_first <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res.valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.count, r_out.value, r_out.addr};
    assign m_axis_tlast  = r_out.last;

endmodule

// ===== src/srb_checker.sv =====
// Port-level checks of the sprite RLE blitter and their bind
`include "assert_macros.svh"

module srb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    `SRB_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    `SRB_ASSERT_IMP(a_empty_is_end, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[39:28] == 12'd0, m_axis_tlast && m_axis_tdata[27:0] == 28'd0)

    `SRB_ASSERT_IMP(a_in_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)

    `SRB_ASSERT(a_out_cause, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind sprite_rle_blitter_unit srb_checker u_srb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
